@@ hdl/ced_pkg.sv @@
// ----------------------------------------------------------------------------
// ced_pkg: shared types, constants and the entity ROM
// Result item layout, status codes and the name-sum lookup table used by the
// character entity decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int unsigned MAX_RES        = 3;  // results one input item can cause
  localparam int unsigned RES_FIFO_DEPTH = 8;  // result queue entries, power of two

  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] MARK_AGRAVE  = 8'h58;  // 'X'
  localparam logic [7:0] MARK_MACRON  = 8'h59;  // 'Y'
  localparam logic [7:0] UTF_AGRAVE_0 = 8'hC3;
  localparam logic [7:0] UTF_AGRAVE_1 = 8'hA0;
  localparam logic [7:0] UTF_MACRON_0 = 8'hCB;
  localparam logic [7:0] UTF_MACRON_1 = 8'h87;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNCLOSED = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic [1:0] status;
  } res_t;

  // Results handed from the decode stage to the result queue at once
  typedef struct packed {
    logic [1:0]              count;
    res_t [MAX_RES-1:0]      items;
  } push_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // Name-sum lookup; zero means the name is unknown
  function automatic logic [7:0] entity_rom(input logic [7:0] sum);
    logic [7:0] c;
    unique case (sum)
      8'd140:  c = 8'h25;
      8'd62:   c = 8'h26;
      8'd80:   c = 8'h23;
      8'd72:   c = 8'h2A;
      8'd126:  c = 8'h24;
      8'd224:  c = 8'h3C;
      8'd219:  c = 8'h3E;
      8'd135:  c = 8'h5F;
      8'd178:  c = 8'h5B;
      8'd184:  c = 8'h5D;
      8'd130:  c = 8'h7C;
      8'd176:  c = 8'h5C;
      8'd161:  c = 8'h5E;
      8'd129:  c = 8'h40;
      8'd166:  c = 8'h7B;
      8'd172:  c = 8'h7D;
      8'd21:   c = 8'h60;
      8'd118:  c = MARK_AGRAVE;
      8'd128:  c = MARK_MACRON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/ced_if.sv @@
// ----------------------------------------------------------------------------
// ced_in_if / ced_out_if: valid/ready channels of the entity decoder
// Input channel carries one string byte, output channel one result item.
// ----------------------------------------------------------------------------
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_string, input status, output ready);
endinterface

@@ hdl/ced_decode.sv @@
// ----------------------------------------------------------------------------
// ced_decode: input register and entity decode stage
// Holds one input item, decodes it against the entity state and hands up to
// three result items to the result queue.
// ----------------------------------------------------------------------------
module ced_decode
  import ced_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ced_in_if.sink      in_i,
  input  logic        agrave_mode_i,
  input  logic        space_ok_i,
  output push_t       push_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;

  logic       in_entity_q, in_entity_d;
  logic [7:0] sum_q, sum_d;
  status_e    err_q, err_d;
  logic [7:0] rom_c;
  push_t      push;

  assign advance    = valid_q && space_ok_i;
  assign in_i.ready = !valid_q || advance;
  assign rom_c      = entity_rom(sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.in_byte;
      last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    in_entity_d = in_entity_q;
    sum_d       = sum_q;
    err_d       = err_q;
    push        = '0;
    if (err_q == ST_OK) begin
      if (!in_entity_q) begin
        if (byte_q == CH_AMP) begin
          in_entity_d = 1'b1;
          sum_d       = 8'h00;
        end else begin
          push.items[0] = '{out_byte: byte_q, byte_valid: 1'b1,
                            end_of_string: 1'b0, status: ST_OK};
          push.count    = 2'd1;
        end
      end else if (is_alnum(byte_q)) begin
        sum_d = sum_q + byte_q;
      end else if (byte_q == CH_SEMI) begin
        in_entity_d = 1'b0;
        if (rom_c == 8'h00) begin
          err_d = ST_UNKNOWN;
        end else if (agrave_mode_i && rom_c == MARK_AGRAVE) begin
          push.items[0] = '{UTF_AGRAVE_0, 1'b1, 1'b0, ST_OK};
          push.items[1] = '{UTF_AGRAVE_1, 1'b1, 1'b0, ST_OK};
          push.count    = 2'd2;
        end else if (agrave_mode_i && rom_c == MARK_MACRON) begin
          push.items[0] = '{UTF_MACRON_0, 1'b1, 1'b0, ST_OK};
          push.items[1] = '{UTF_MACRON_1, 1'b1, 1'b0, ST_OK};
          push.count    = 2'd2;
        end else begin
          push.items[0] = '{rom_c, 1'b1, 1'b0, ST_OK};
          push.count    = 2'd1;
        end
      end else begin
        err_d = ST_UNCLOSED;
      end
    end
    if (last_q) begin
      if (err_d == ST_OK && in_entity_d) begin
        err_d = ST_UNCLOSED;
      end
      push.items[push.count] = '{8'h00, 1'b0, 1'b1, err_d};
      push.count             = push.count + 2'd1;
      in_entity_d            = 1'b0;
      sum_d                  = 8'h00;
      err_d                  = ST_OK;
    end
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_entity_q <= 1'b0;
      sum_q       <= 8'h00;
      err_q       <= ST_OK;
    end else if (advance) begin
      in_entity_q <= in_entity_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
    end
  end

  assign push_o = push;

endmodule

@@ hdl/ced_result_fifo.sv @@
// ----------------------------------------------------------------------------
// ced_result_fifo: result queue
// Takes up to three result items a cycle and delivers one a cycle while the output channel is ready.
// ----------------------------------------------------------------------------
module ced_result_fifo
  import ced_pkg::*;
#(
  parameter int unsigned Depth = RES_FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  push_t                       push_i,
  output logic                        space_ok_o,
  output logic [$clog2(Depth+1)-1:0]  level_o,
  ced_out_if.source                   out_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;
  res_t            head;

  assign head       = mem_q[rd_ptr_q];
  assign pop        = out_o.valid && out_o.ready;
  assign space_ok_o = count_q <= CntW'(Depth - MAX_RES);
  assign level_o    = count_q;

  assign out_o.valid         = count_q != '0;
  assign out_o.out_byte      = head.out_byte;
  assign out_o.byte_valid    = head.byte_valid;
  assign out_o.end_of_string = head.end_of_string;
  assign out_o.status        = head.status;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (push_i.count > 2'(k)) begin
        mem_q[wr_ptr_q + PtrW'(k)] <= push_i.items[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

endmodule

@@ hdl/char_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// char_entity_decoder: named character entity decoder
// Passes string bytes through and replaces "&name;" entities by their bytes.
// ----------------------------------------------------------------------------
// One input item (a byte of a string, last_byte marking its end) is taken per
// cycle while the decode stage does not stall. An item is decoded straight out
// of the input register, and its results are written into the result queue
// when the decode stage advances. Results leave through an eight-entry result
// queue, one per cycle while the output channel is ready:
// a plain byte gives one item, an agrave or macron entity in agrave mode two,
// and the last byte of a string adds a closing status item. The decode stage
// stalls while fewer than three queue entries are free, so the sustained rate
// is one input item a cycle as long as results are drained at least as fast as
// they are produced. agrave_mode is written through cfg_we_i and cfg_wdata_i;
// the user must do so only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module char_entity_decoder
  import ced_pkg::*;
#(
  parameter int unsigned FifoDepth = RES_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ced_in_if.sink     in_i,
  ced_out_if.source  out_o
);

  logic                           agrave_mode_q;
  logic                           space_ok;
  logic [$clog2(FifoDepth+1)-1:0] level;
  push_t                          push;

  // hold the mode register; it only changes on an explicit write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agrave_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      agrave_mode_q <= cfg_wdata_i;
    end
  end

  // input register, entity state and decode
  ced_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .agrave_mode_i (agrave_mode_q),
    .space_ok_i    (space_ok),
    .push_o        (push)
  );

  // result queue towards the output channel
  ced_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .level_o    (level),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  // never push results unless the queue had room for a full item's worth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd0 |-> space_ok)
    else $error("result pushed without queue space");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= ($clog2(FifoDepth+1))'(FifoDepth))
    else $error("result queue level out of range");

  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_of_string |-> !out_o.byte_valid && out_o.out_byte == 8'h00)
    else $error("closing status item carries a byte");
`endif

endmodule

@@ tb/ced_result_checker.sv @@
// ----------------------------------------------------------------------------
// ced_result_checker: result predictor and comparator for the entity decoder
// Watches both channels and the agrave_mode write port, works out the decoded
// items each accepted string byte must cause and compares them in order with
// what the decoder hands out.
// ----------------------------------------------------------------------------
module ced_result_checker
  import ced_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  ced_in_if    in_ch_i,
  ced_out_if   out_ch_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [7:0] entity_table [256];

  logic       agrave_on   = 1'b0;
  logic       inside_name = 1'b0;
  logic [7:0] name_total  = 8'h00;
  status_e    err_state   = ST_OK;
  res_t       decoded_q [$];
  int         fails       = 0;

  // Name sum to decoded byte; zero marks an unknown name
  initial begin
    foreach (entity_table[i]) entity_table[i] = 8'h00;
    entity_table[140] = 8'h25;
    entity_table[62]  = 8'h26;  // amp
    entity_table[80]  = 8'h23;
    entity_table[72]  = 8'h2A;
    entity_table[126] = 8'h24;
    entity_table[224] = 8'h3C;  // lt
    entity_table[219] = 8'h3E;  // gt
    entity_table[135] = 8'h5F;
    entity_table[178] = 8'h5B;
    entity_table[184] = 8'h5D;
    entity_table[130] = 8'h7C;
    entity_table[176] = 8'h5C;
    entity_table[161] = 8'h5E;
    entity_table[129] = 8'h40;
    entity_table[166] = 8'h7B;
    entity_table[172] = 8'h7D;
    entity_table[21]  = 8'h60;
    entity_table[118] = MARK_AGRAVE;
    entity_table[128] = MARK_MACRON;
  end

  function automatic logic is_name_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z");
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    decoded_q.push_back('{out_byte: b, byte_valid: 1'b1, end_of_string: 1'b0,
                          status: ST_OK});
  endfunction

  // Advance the decoder state by one string byte and queue its results
  function automatic void predict_decoded(input logic [7:0] b, input logic last);
    logic [7:0] hit;
    if (err_state == ST_OK) begin
      if (!inside_name) begin
        if (b == CH_AMP) begin
          inside_name = 1'b1;
          name_total  = 8'h00;
        end else begin
          queue_byte(b);
        end
      end else if (is_name_char(b)) begin
        name_total = name_total + b;
      end else if (b == CH_SEMI) begin
        hit         = entity_table[name_total];
        inside_name = 1'b0;
        if (hit == 8'h00) begin
          err_state = ST_UNKNOWN;
        end else if (agrave_on && hit == MARK_AGRAVE) begin
          queue_byte(UTF_AGRAVE_0);
          queue_byte(UTF_AGRAVE_1);
        end else if (agrave_on && hit == MARK_MACRON) begin
          queue_byte(UTF_MACRON_0);
          queue_byte(UTF_MACRON_1);
        end else begin
          queue_byte(hit);
        end
      end else begin
        err_state = ST_UNCLOSED;
      end
    end
    if (last) begin
      if (err_state == ST_OK && inside_name) err_state = ST_UNCLOSED;
      decoded_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0, end_of_string: 1'b1,
                            status: err_state});
      inside_name = 1'b0;
      name_total  = 8'h00;
      err_state   = ST_OK;
    end
  endfunction

  function automatic void report(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      agrave_on   = 1'b0;
      inside_name = 1'b0;
      name_total  = 8'h00;
      err_state   = ST_OK;
      decoded_q.delete();
    end else begin
      if (cfg_we_i) agrave_on = cfg_wdata_i;
      if (in_ch_i.valid && in_ch_i.ready)
        predict_decoded(in_ch_i.in_byte, in_ch_i.last_byte);
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0h/%0b/%0b/%0d",
                   $time, out_ch_i.out_byte, out_ch_i.byte_valid,
                   out_ch_i.end_of_string, out_ch_i.status);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          report("out_byte", want.out_byte, out_ch_i.out_byte);
          report("byte_valid", want.byte_valid, out_ch_i.byte_valid);
          report("end_of_string", want.end_of_string, out_ch_i.end_of_string);
          report("status", want.status, out_ch_i.status);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= decoded_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the character entity decoder
// Feeds strings of plain bytes and named entities through the valid/ready
// input channel with random gaps, drains results with random stalls, flips
// agrave_mode between phases and lets ced_result_checker judge every item.
// ----------------------------------------------------------------------------
module tb_top
  import ced_pkg::*;
();

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   pending;

  // Idling profile of the current phase: calm means no gaps on that side
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int   rx_hold = 0;

  // Bytes of the string being built, sent in order with last_byte on the tail
  logic [7:0] text_q [$];
  int         useful_items;

  ced_in_if  in_ch ();
  ced_out_if out_ch ();

  char_entity_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  ced_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side back-pressure: mostly short ready/stall runs, now and then a
  // long stall; hold ready high throughout a calm phase.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ch.ready <= 1'b1;
        rx_hold      <= $urandom_range(0, 7);
      end else if (r < 95) begin
        out_ch.ready <= 1'b0;
        rx_hold      <= $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b0;
        rx_hold      <= $urandom_range(10, 40);
      end
    end
  end

  function automatic logic is_alnum_byte(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z");
  endfunction

  function automatic logic [7:0] rand_alnum();
    int k;
    k = $urandom_range(0, 61);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 36) return 8'(8'h41 + k - 10);
    return 8'(8'h61 + k - 36);
  endfunction

  // Name sums that the decoder knows
  function automatic logic [7:0] known_sum();
    case ($urandom_range(0, 18))
      0:  return 8'd140;
      1:  return 8'd62;
      2:  return 8'd80;
      3:  return 8'd72;
      4:  return 8'd126;
      5:  return 8'd224;
      6:  return 8'd219;
      7:  return 8'd135;
      8:  return 8'd178;
      9:  return 8'd184;
      10: return 8'd130;
      11: return 8'd176;
      12: return 8'd161;
      13: return 8'd129;
      14: return 8'd166;
      15: return 8'd172;
      16: return 8'd21;
      17: return 8'd118;
      default: return 8'd128;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Append "&name;" whose letters sum to the wanted value: a random prefix,
  // then a two- or three-character tail that closes the gap. Between them the
  // two tail lengths reach every sum modulo 256.
  task automatic add_entity(input logic [7:0] target);
    logic [7:0] acc;
    logic [7:0] gap;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic       done;
    text_q.push_back(CH_AMP);
    acc = 8'h00;
    repeat ($urandom_range(0, 3)) begin
      c1 = rand_alnum();
      text_q.push_back(c1);
      acc = acc + c1;
    end
    gap  = target - acc;
    done = 1'b0;
    for (int k = 0; k < 2000 && !done; k++) begin
      c1 = rand_alnum();
      c2 = rand_alnum();
      if (k % 2 == 0) begin
        c3 = gap - c1;
        if (is_alnum_byte(c3)) begin
          text_q.push_back(c1);
          text_q.push_back(c3);
          done = 1'b1;
        end
      end else begin
        c3 = gap - c1 - c2;
        if (is_alnum_byte(c3)) begin
          text_q.push_back(c1);
          text_q.push_back(c2);
          text_q.push_back(c3);
          done = 1'b1;
        end
      end
    end
    text_q.push_back(CH_SEMI);
  endtask

  // Offer one byte; hold valid across back-to-back items, drop it only for a gap
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      push_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Wait for every predicted item, then cover items still in flight that
  // cause no result (an item waits in the input register until the result
  // queue has room, and its results are then written into the queue)
  task automatic wait_drained();
    int spin;
    in_ch.valid <= 1'b0;
    spin = 0;
    @(posedge clk);
    while (pending != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random string. Plain bytes and well-formed entities dominate; unknown names, a bad
  // character (after which the rest of the string is ignored) and a name
  // left open at the end make up the rest. Bytes the decoder will ignore do
  // not count as useful items.
  task automatic build_random_text();
    int         r;
    int         before_len;
    logic [7:0] b;
    logic       stop;
    stop = 1'b0;
    for (int t = $urandom_range(1, 8); t > 0 && !stop; t--) begin
      r          = $urandom_range(0, 99);
      before_len = text_q.size();
      if (r < 50) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_AMP) b = b ^ 8'h01;
        text_q.push_back(b);
      end else if (r < 80) begin
        add_entity(known_sum());
      end else if (r < 86) begin
        add_entity(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        // bad character inside a name, then trailing bytes that are swallowed
        text_q.push_back(CH_AMP);
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_alnum());
        useful_items += text_q.size() - before_len;
        do b = 8'($urandom_range(0, 255)); while (is_alnum_byte(b) || b == CH_SEMI);
        text_q.push_back(b);
        repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
        before_len = text_q.size();
        stop       = 1'b1;
      end else begin
        // name still open when the string ends
        text_q.push_back(CH_AMP);
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_alnum());
        stop = 1'b1;
      end
      useful_items += text_q.size() - before_len;
    end
  endtask

  initial begin
    int phase_start;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    useful_items    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, agrave mode off: byte extremes and NUL pass through, amp
    write_mode(1'b0);
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    add_text("&amp;");
    send_text();
    // empty name is unknown
    add_text("&;");
    send_text();
    // high byte inside a name, then a swallowed ';' under the sticky error
    add_text("&a");
    text_q.push_back(8'h80);
    add_text(";");
    send_text();
    // name left open at the end of the string
    add_text("&gt");
    send_text();

    // Directed, agrave mode on: both markers expand, then a second ampersand
    wait_drained();
    write_mode(1'b1);
    add_text("&v;&0P;&&");
    send_text();

    // Random phases: alternate the mode, first phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_mode(ph % 2 == 0);
      tx_calm     = (ph == 0) || ($urandom_range(0, 3) == 0);
      rx_calm     = (ph == 0) || ($urandom_range(0, 3) == 0);
      phase_start = useful_items;
      while (useful_items - phase_start < 28) begin
        build_random_text();
        send_text();
      end
    end

    wait_drained();
    if (pending != 0)
      $display("%0t: %0d decoded items never arrived", $time, pending);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ced_pkg.sv
hdl/ced_if.sv
hdl/ced_decode.sv
hdl/ced_result_fifo.sv
hdl/char_entity_decoder.sv
tb/ced_result_checker.sv
tb/tb_top.sv
